[rtl/ttb_pkg.sv]
package ttb_pkg;
    localparam int unsigned FieldW   = 32;
    localparam int unsigned DeltaW   = FieldW + 1;
    localparam int unsigned AccW     = 2 * DeltaW + 1;
    localparam int unsigned FracW    = 16;
    localparam int unsigned DivNumW  = AccW + FracW;
    localparam int unsigned MulSteps = DeltaW;
    localparam int unsigned DivSteps = DivNumW;
    localparam int unsigned NumJobs  = 7;

    localparam logic [1:0] CornerA = 2'd0;
    localparam logic [1:0] CornerB = 2'd1;
    localparam logic [1:0] CornerC = 2'd2;

    typedef struct packed {
        logic start;
        logic clear;
        logic neg;
    } t_mac_req;
endpackage

[rtl/triangle_tangent_bitangent.sv]
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | i_corner, i_pos_x/y/z, i_tex_u/v
// output   | o_valid | i_stall | o_tangent_x/y/z, o_bitangent_x/y/z, o_degenerate, o_clipped
// corners 0 and 1 (and the unused code 3) are taken without stalling the input
// corner 2 runs 14 serial products in one bit-per-cycle multiply-accumulate
// unit, two for the determinant and two per job, each job then dividing once in
// one bit-per-cycle restoring divider; a zero determinant ends after two products
// synchronous active-low reset clears the corner stores and all control
// the input stays stalled while a triangle is computed; a finished result
// waits in the output register, and corner 0/1 transfers go on meanwhile
module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_corner,
    input  logic signed [FieldW-1:0] i_pos_x,
    input  logic signed [FieldW-1:0] i_pos_y,
    input  logic signed [FieldW-1:0] i_pos_z,
    input  logic signed [FieldW-1:0] i_tex_u,
    input  logic signed [FieldW-1:0] i_tex_v,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [FieldW-1:0] o_tangent_x,
    output logic signed [FieldW-1:0] o_tangent_y,
    output logic signed [FieldW-1:0] o_tangent_z,
    output logic signed [FieldW-1:0] o_bitangent_x,
    output logic signed [FieldW-1:0] o_bitangent_y,
    output logic signed [FieldW-1:0] o_bitangent_z,
    output logic                     o_degenerate,
    output logic                     o_clipped
);
    typedef enum logic [2:0] {
        S_IDLE, S_MSTART, S_MWAIT, S_DSTART, S_DWAIT, S_OUT
    } t_state;

    t_state                   r_state;
    logic signed [FieldW-1:0] r_c0 [5];
    logic signed [FieldW-1:0] r_c1 [5];
    logic signed [DeltaW-1:0] r_e1 [3];
    logic signed [DeltaW-1:0] r_e2 [3];
    logic signed [DeltaW-1:0] r_d1u, r_d1v, r_d2u, r_d2v;
    logic signed [AccW-1:0]   r_det;
    logic [2:0]               r_job;
    logic                     r_term;
    logic [FieldW-1:0]        r_res [6];
    logic                     r_clip;
    logic                     r_degen;
    logic                     r_out_valid;
    logic [FieldW-1:0]        r_out [6];
    logic                     r_out_degen;
    logic                     r_out_clip;

    logic                     w_in_xfer;
    logic signed [FieldW-1:0] w_in [5];
    logic signed [DeltaW-1:0] w_a, w_b;
    t_mac_req                 w_req;
    logic                     w_mac_done;
    logic signed [AccW-1:0]   w_acc;
    logic                     w_div_done;
    logic [FieldW-1:0]        w_q;
    logic                     w_q_clip;
    logic                     w_out_free;

    assign w_in = '{i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v};
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_xfer  = i_valid & ~o_stall;
    assign w_out_free = ~r_out_valid | ~i_stall;

    // operand select: job 0 is the determinant, jobs 1-3 tangent, 4-6 bitangent
    // term 0 adds the first product, term 1 subtracts the second
    always_comb begin
        w_a = r_d1u;
        w_b = r_d2v;
        case (r_job)
            3'd0: begin
                w_a = r_term ? r_d2u : r_d1u;
                w_b = r_term ? r_d1v : r_d2v;
            end
            3'd1, 3'd2, 3'd3: begin
                w_a = r_term ? r_d1v : r_d2v;
                w_b = r_term ? r_e2[2'(r_job - 3'd1)] : r_e1[2'(r_job - 3'd1)];
            end
            3'd4, 3'd5, 3'd6: begin
                w_a = r_term ? r_d2u : r_d1u;
                w_b = r_term ? r_e1[2'(r_job - 3'd4)] : r_e2[2'(r_job - 3'd4)];
            end
            default: begin
                w_a = r_d1u;
                w_b = r_d2v;
            end
        endcase
    end

    assign w_req.start = (r_state == S_MSTART);
    assign w_req.clear = ~r_term;
    assign w_req.neg   = r_term;

    ttb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    // the accumulator holds the numerator while the divider runs
    ttb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (w_acc),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_q     (w_q),
        .o_clip  (w_q_clip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_job       <= '0;
            r_term      <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_c0[i] <= '0;
                r_c1[i] <= '0;
            end
        end else begin
            // in S_OUT the output register is reloaded below instead
            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (i_corner == CornerA) begin
                            for (int i = 0; i < 5; i++) r_c0[i] <= w_in[i];
                        end else if (i_corner == CornerB) begin
                            for (int i = 0; i < 5; i++) r_c1[i] <= w_in[i];
                        end else if (i_corner == CornerC) begin
                            // edges and texture deltas, one bit wider than the fields
                            for (int i = 0; i < 3; i++) begin
                                r_e1[i] <= DeltaW'(r_c1[i]) - DeltaW'(r_c0[i]);
                                r_e2[i] <= DeltaW'(w_in[i]) - DeltaW'(r_c0[i]);
                            end
                            r_d1u   <= DeltaW'(r_c1[3]) - DeltaW'(r_c0[3]);
                            r_d1v   <= DeltaW'(r_c1[4]) - DeltaW'(r_c0[4]);
                            r_d2u   <= DeltaW'(w_in[3]) - DeltaW'(r_c0[3]);
                            r_d2v   <= DeltaW'(w_in[4]) - DeltaW'(r_c0[4]);
                            r_job   <= '0;
                            r_term  <= 1'b0;
                            r_clip  <= 1'b0;
                            r_degen <= 1'b0;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mac_done) begin
                        if (!r_term) begin
                            r_term  <= 1'b1;
                            r_state <= S_MSTART;
                        end else begin
                            r_term <= 1'b0;
                            if (r_job == 3'd0) begin
                                r_det <= w_acc;
                                if (w_acc == '0) begin
                                    // zero determinant: zero vectors, flag set
                                    r_degen <= 1'b1;
                                    for (int i = 0; i < 6; i++) r_res[i] <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_job   <= 3'd1;
                                    r_state <= S_MSTART;
                                end
                            end else begin
                                r_state <= S_DSTART;
                            end
                        end
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_res[r_job - 3'd1] <= w_q;
                        r_clip <= r_clip | w_q_clip;
                        if (r_job == 3'(NumJobs - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_job   <= r_job + 3'd1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_out_degen <= r_degen;
                        r_out_clip  <= r_clip & ~r_degen;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_tangent_x   = r_out[0];
    assign o_tangent_y   = r_out[1];
    assign o_tangent_z   = r_out[2];
    assign o_bitangent_x = r_out[3];
    assign o_bitangent_y = r_out[4];
    assign o_bitangent_z = r_out[5];
    assign o_degenerate  = r_out_degen;
    assign o_clipped     = r_out_clip;
endmodule

[rtl/ttb_mac.sv]
module ttb_mac
    import ttb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_req                 i_req,
    input  logic signed [DeltaW-1:0] i_a,
    input  logic signed [DeltaW-1:0] i_b,
    output logic                     o_done,
    output logic signed [AccW-1:0]   o_acc
);
    logic                   r_busy;
    logic                   r_done;
    logic [5:0]             r_cnt;
    logic [AccW-1:0]        r_a;
    logic [DeltaW-1:0]      r_b;
    logic [AccW-1:0]        r_acc;
    logic                   r_neg;
    logic [AccW-1:0]        n_acc;
    logic [AccW-1:0]        w_term;
    logic                   w_last;

    assign w_last = (r_cnt == 6'(MulSteps - 1));
    assign w_term = r_b[0] ? r_a : '0;

    // sign bit of the multiplier has negative weight
    always_comb begin
        if (r_neg ^ w_last) begin
            n_acc = r_acc - w_term;
        end else begin
            n_acc = r_acc + w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= AccW'(i_a);
                r_b    <= i_b;
                r_neg  <= i_req.neg;
                if (i_req.clear) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= {r_a[AccW-2:0], 1'b0};
                r_b   <= {1'b0, r_b[DeltaW-1:1]};
                r_cnt <= r_cnt + 6'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

[rtl/ttb_div.sv]
module ttb_div
    import ttb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [AccW-1:0] i_num,
    input  logic signed [AccW-1:0] i_den,
    output logic                   o_done,
    output logic [FieldW-1:0]      o_q,
    output logic                   o_clip
);
    logic                 r_busy;
    logic                 r_done;
    logic [6:0]           r_cnt;
    logic                 r_neg;
    logic                 r_ovf;
    logic [DivNumW-1:0]   r_n;
    logic [AccW-1:0]      r_d;
    logic [AccW:0]        r_rem;
    logic [FieldW:0]      r_q;
    logic [AccW:0]        w_shift;
    logic                 w_ge;
    logic [AccW-1:0]      w_num_abs;
    logic [AccW-1:0]      w_den_abs;
    logic [FieldW-1:0]    w_mag;

    assign w_num_abs = i_num[AccW-1] ? AccW'(-i_num) : AccW'(i_num);
    assign w_den_abs = i_den[AccW-1] ? AccW'(-i_den) : AccW'(i_den);
    assign w_shift   = {r_rem[AccW-1:0], r_n[DivNumW-1]};
    assign w_ge      = (w_shift >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[AccW-1] ^ i_den[AccW-1];
                r_n    <= {w_num_abs, FracW'(0)};
                r_d    <= w_den_abs;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_shift - {1'b0, r_d}) : w_shift;
                r_n   <= {r_n[DivNumW-2:0], 1'b0};
                r_q   <= {r_q[FieldW-1:0], w_ge};
                r_ovf <= r_ovf | r_q[FieldW];
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // saturate to the signed 32-bit range
    always_comb begin
        w_mag = r_q[FieldW-1:0];
        if (!r_neg) begin
            o_clip = r_ovf | r_q[FieldW] | r_q[FieldW-1];
            o_q    = o_clip ? {1'b0, {(FieldW-1){1'b1}}} : w_mag;
        end else begin
            o_clip = r_ovf | r_q[FieldW] | (r_q[FieldW-1] & (|r_q[FieldW-2:0]));
            o_q    = o_clip ? {1'b1, {(FieldW-1){1'b0}}} : (~w_mag + FieldW'(1));
        end
    end

    assign o_done = r_done;
endmodule

[rtl/ttb_checker.sv]
module ttb_checker
    import ttb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [1:0]        i_corner,
    input logic              o_valid,
    input logic              i_stall,
    input logic [FieldW-1:0] o_tangent_x,
    input logic [FieldW-1:0] o_bitangent_z,
    input logic              o_degenerate,
    input logic              o_clipped
);
    // a degenerate result carries zero vectors and no clip flag
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_tangent_x == '0 && o_bitangent_z == '0 && !o_clipped))
        else $error("degenerate result not zero");

    // the input is stalled once a corner 2 transfer starts a triangle
    a_busy_after_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_corner == CornerC) |=> o_stall)
        else $error("input not stalled after corner 2");

    // a corner 2 transfer brings no new result out right behind it
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_corner == CornerC) |=> ##1 !$rose(o_valid))
        else $error("result too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_tangent_x)))
        else $error("stalled result dropped");
endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_corner      (i_corner),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_tangent_x   (o_tangent_x),
    .o_bitangent_z (o_bitangent_z),
    .o_degenerate  (o_degenerate),
    .o_clipped     (o_clipped)
);

[tb/tb.sv]
module tb
    import ttb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one tangent-space result as the block presents it
    typedef struct packed {
        logic signed [FieldW-1:0] tan_x;
        logic signed [FieldW-1:0] tan_y;
        logic signed [FieldW-1:0] tan_z;
        logic signed [FieldW-1:0] bit_x;
        logic signed [FieldW-1:0] bit_y;
        logic signed [FieldW-1:0] bit_z;
        logic                     degenerate;
        logic                     clipped;
    } t_frame;

    // one directed row: corner code, x y z u v, and a typed-in answer where obvious
    typedef struct {
        logic [1:0]               corner;
        logic signed [FieldW-1:0] val [5];
        bit                       typed;
        t_frame                   answer;
    } t_row;

    localparam logic [1:0] CornerSkip = 2'd3;   // ignored code
    localparam logic [31:0] One   = 32'h0001_0000;
    localparam logic [31:0] MaxP  = 32'h7fff_ffff;
    localparam logic [31:0] MinN  = 32'h8000_0000;
    localparam int unsigned NumItems = 600;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_corner = CornerA;
    logic signed [FieldW-1:0] i_pos_x = '0;
    logic signed [FieldW-1:0] i_pos_y = '0;
    logic signed [FieldW-1:0] i_pos_z = '0;
    logic signed [FieldW-1:0] i_tex_u = '0;
    logic signed [FieldW-1:0] i_tex_v = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [FieldW-1:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic signed [FieldW-1:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;
    logic                     o_degenerate, o_clipped;

    triangle_tangent_bitangent i_dut (.*);

    // predictor state: the two stored corners, x y z u v
    logic signed [FieldW-1:0] corner0_copy [5];
    logic signed [FieldW-1:0] corner1_copy [5];

    t_frame frames_pending [$];
    int     error_count = 0;
    bit     quiet = 1'b0;       // no idling on either side while set

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #60ms;
        $display("tb: done, errors");
        $finish;
    end

    // Q16.16 quotient of two Q32.32 values, returns {clip, value}
    function automatic logic [32:0] fixed_quotient(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
        logic [127:0] n, d, q;
        logic         neg;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = (n << FracW) / d;
        if (!neg) begin
            if (q > 128'h7fff_ffff) return {1'b1, MaxP};
            return {1'b0, q[31:0]};
        end
        if (q > 128'h8000_0000) return {1'b1, MinN};
        return {1'b0, -q[31:0]};
    endfunction

    // corners 0/1 update the stores; corner 2 computes the frame
    function automatic bit tangent_frame(input logic [1:0] corner,
                                         input logic signed [FieldW-1:0] v [5],
                                         output t_frame f);
        logic signed [127:0] p0 [5], p1 [5], p2 [5], e1 [3], e2 [3];
        logic signed [127:0] d1u, d1v, d2u, d2v, det;
        logic [32:0]         tq [3], bq [3];
        f = '0;
        if (corner == CornerA || corner == CornerB) begin
            for (int i = 0; i < 5; i++) begin
                if (corner == CornerA) corner0_copy[i] = v[i];
                else corner1_copy[i] = v[i];
            end
            return 1'b0;
        end
        if (corner != CornerC) return 1'b0;
        for (int i = 0; i < 5; i++) begin
            p0[i] = corner0_copy[i];
            p1[i] = corner1_copy[i];
            p2[i] = v[i];
        end
        for (int i = 0; i < 3; i++) begin
            e1[i] = p1[i] - p0[i];
            e2[i] = p2[i] - p0[i];
        end
        d1u = p1[3] - p0[3];
        d1v = p1[4] - p0[4];
        d2u = p2[3] - p0[3];
        d2v = p2[4] - p0[4];
        det = d1u * d2v - d2u * d1v;
        if (det == 0) begin
            f.degenerate = 1'b1;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            tq[i] = fixed_quotient(d2v * e1[i] - d1v * e2[i], det);
            bq[i] = fixed_quotient(d1u * e2[i] - d2u * e1[i], det);
        end
        f.tan_x = tq[0][31:0];
        f.tan_y = tq[1][31:0];
        f.tan_z = tq[2][31:0];
        f.bit_x = bq[0][31:0];
        f.bit_y = bq[1][31:0];
        f.bit_z = bq[2][31:0];
        f.clipped = tq[0][32] | tq[1][32] | tq[2][32] | bq[0][32] | bq[1][32] | bq[2][32];
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // mix of full-range, moderate, tiny and extreme coordinates
    function automatic logic signed [FieldW-1:0] coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            2: return $signed($urandom_range(511)) - 256;
            default: begin
                case ($urandom_range(2))
                    0: return MinN;
                    1: return MaxP;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // one transfer on the input side, with random gaps first
    task automatic send(input logic [1:0] corner, input logic signed [FieldW-1:0] v [5],
                        input bit typed, input t_frame answer);
        t_frame f;
        while (!quiet && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_corner <= corner;
        i_pos_x  <= v[0];
        i_pos_y  <= v[1];
        i_pos_z  <= v[2];
        i_tex_u  <= v[3];
        i_tex_v  <= v[4];
        do @(posedge i_clk); while (o_stall);
        if (tangent_frame(corner, v, f)) begin
            frames_pending.insert(frames_pending.size(), typed ? answer : f);
        end
    endtask

    // output side: random stall and the result check
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frames_pending.size() == 0) begin
                report("unexpected transfer", o_tangent_x, '0);
            end else begin
                want = frames_pending.pop_front();
                if (o_tangent_x !== want.tan_x) report("tangent_x", o_tangent_x, want.tan_x);
                if (o_tangent_y !== want.tan_y) report("tangent_y", o_tangent_y, want.tan_y);
                if (o_tangent_z !== want.tan_z) report("tangent_z", o_tangent_z, want.tan_z);
                if (o_bitangent_x !== want.bit_x)
                    report("bitangent_x", o_bitangent_x, want.bit_x);
                if (o_bitangent_y !== want.bit_y)
                    report("bitangent_y", o_bitangent_y, want.bit_y);
                if (o_bitangent_z !== want.bit_z)
                    report("bitangent_z", o_bitangent_z, want.bit_z);
                if (o_degenerate !== want.degenerate)
                    report("degenerate", 32'(o_degenerate), 32'(want.degenerate));
                if (o_clipped !== want.clipped)
                    report("clipped", 32'(o_clipped), 32'(want.clipped));
            end
        end
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);
    end

    initial begin
        t_row                     rows [$];
        t_row                     r;
        t_frame                   unit;
        logic signed [FieldW-1:0] v [5];
        logic [1:0]               c;
        int                       sent;

        for (int i = 0; i < 5; i++) begin
            corner0_copy[i] = '0;
            corner1_copy[i] = '0;
        end

        // corner 2 straight after reset: stores are zero, so det is zero
        r = '{CornerC, '{0, 0, 0, 0, 0}, 1'b1, '0};
        r.answer.degenerate = 1'b1;
        rows.insert(rows.size(), r);
        // unit triangle: tangent is e1, bitangent is e2
        unit = '0;
        unit.tan_x = One;
        unit.bit_y = One;
        rows.insert(rows.size(), '{CornerA, '{0, 0, 0, 0, 0}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerB, '{One, 0, 0, One, 0}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{0, One, 0, 0, One}, 1'b1, unit});
        // ignored code with extreme payload, then the same triangle again
        rows.insert(rows.size(), '{CornerSkip, '{MinN, MaxP, MinN, MaxP, MinN}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{0, One, 0, 0, One}, 1'b1, unit});
        // collinear texture deltas but nonzero positions: degenerate
        r = '{CornerC, '{One, One, One, 2 * One, 0}, 1'b1, '0};
        r.answer.degenerate = 1'b1;
        rows.insert(rows.size(), '{CornerB, '{MaxP, MinN, One, One, 0}, 1'b0, '0});
        rows.insert(rows.size(), r);
        // extreme corners, first with a full texture spread, then a tiny one: saturation
        rows.insert(rows.size(), '{CornerA, '{MinN, MinN, MinN, MinN, MinN}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerB, '{MaxP, MaxP, MaxP, MaxP, MinN}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{MaxP, MinN, MaxP, MinN, MaxP}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerA, '{0, 0, 0, 0, 0}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerB, '{MaxP, MinN, MaxP, 1, 0}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{MinN, MaxP, MinN, 0, 1}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{-1, -1, -1, -1, -1}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerA, '{-1, 1, -One, 3, -7}, 1'b0, '0});
        rows.insert(rows.size(), '{CornerC, '{One, -One, 5, -3, 7}, 1'b0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send(rows[k].corner, rows[k].val, rows[k].typed, rows[k].answer);

        // mostly whole triangles with random content, some noise corners
        sent = 0;
        while (sent < NumItems) begin
            quiet = (sent >= 250 && sent < 350);
            for (int k = 0; k < 3; k++) begin
                c = k[1:0];
                if ($urandom_range(99) < 15) c = 2'($urandom_range(3));
                for (int i = 0; i < 5; i++) v[i] = coord();
                send(c, v, 1'b0, '0);
                if (c != CornerSkip) sent++;
            end
        end
        quiet = 1'b0;

        i_valid <= 1'b0;
        while (frames_pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule

[files.f]
rtl/ttb_pkg.sv
rtl/ttb_mac.sv
rtl/ttb_div.sv
rtl/triangle_tangent_bitangent.sv
rtl/ttb_checker.sv
tb/tb.sv
